[rtl/core/fobs_pkg.sv]
// Shared types, constants and constant tables for the fractional-octave band summer.
package fobs_pkg;

    // Log table size and index width.
    localparam int LOG_TAB_DEPTH = 256;
    localparam int LOG_TAB_AW    = 9;

    // Fixed-point constants.
    localparam logic [19:0] LOG2_16000_Q16 = 20'd915262;
    localparam logic [23:0] LOG2_10_DIV10  = 24'd5573271;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [5:0]  BANDS_MAX      = 6'd48;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_BANDS = 1'b0,
        REG_GAIN  = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG_LO,
        ST_LOG_HI,
        ST_LOG_SUM,
        ST_BAND,
        ST_LEVEL,
        ST_PWR_WAIT,
        ST_DECIDE,
        ST_ACCUM,
        ST_CHECK_LAST,
        ST_Q_START,
        ST_Q_WAIT,
        ST_CEN_START,
        ST_CEN_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_AMP,
        ST_VMUL,
        ST_VDIV_START,
        ST_VDIV_WAIT,
        ST_EMIT
    } seq_state_t;

    // Control of the power-of-two unit.
    typedef struct packed {
        logic start;
        logic scale32;
    } exp_ctl_t;

    // Control of the divide and square-root unit.
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } ds_ctl_t;

    typedef logic [LOG_TAB_DEPTH:0][16:0] log_tab_t;
    typedef logic [15:0][31:0]            exp_roots_t;

    // Integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Table of log2(1 + j/depth) in Q16, built by repeated squaring.
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] x;
        logic [31:0] res;
        for (int j = 0; j <= LOG_TAB_DEPTH; j++) begin
            x   = (64'd1 << 30) + ((64'(j) << 30) / LOG_TAB_DEPTH);
            res = 32'd0;
            for (int i = 0; i < 20; i++) begin
                x   = (x * x) >> 30;
                res = res << 1;
                if (x >= (64'd1 << 31)) begin
                    x   = x >> 1;
                    res = res | 32'd1;
                end
            end
            t[j] = 17'((res + 32'd8) >> 4);
        end
        return t;
    endfunction

    // Roots 2^(2^-i) in Q30 for i = 1 to 16.
    function automatic exp_roots_t build_exp_roots();
        exp_roots_t  t;
        logic [63:0] r;
        r    = isqrt64(64'd1 << 61);
        t[0] = r[31:0];
        for (int i = 1; i < 16; i++) begin
            r    = isqrt64(r << 30);
            t[i] = r[31:0];
        end
        return t;
    endfunction

    localparam log_tab_t   LOG_TAB   = build_log_tab();
    localparam exp_roots_t EXP_ROOTS = build_exp_roots();

endpackage

[rtl/core/fobs_exp2.sv]
// Iterative power-of-two unit: one rounded Q30 multiply per exponent fraction bit.
module fobs_exp2
    import fobs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  exp_ctl_t           ctl,
    input  logic signed [27:0] expo,
    output logic               done,
    output logic [63:0]        result
);

    logic               busy_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        m_reg;
    logic [15:0]        fr_reg;
    logic signed [11:0] ip_reg;
    logic               scale_reg;
    logic               done_reg;
    logic [63:0]        res_reg;

    logic [62:0]        prod;
    logic [32:0]        prod_rnd;
    logic               fr_bit;
    logic signed [12:0] sh;
    logic [5:0]         nsh;
    logic [63:0]        res_next;

    // Rounded multiply by the root picked by the current fraction bit.
    assign prod     = 63'(m_reg) * 63'(EXP_ROOTS[cnt_reg[3:0]]);
    assign prod_rnd = 33'((prod + 63'(64'd1 << 29)) >> 30);
    assign fr_bit   = fr_reg[4'd15 - cnt_reg[3:0]];

    // Final scaling by the integer part, rounding half up and saturating.
    assign sh  = 13'(ip_reg) + (scale_reg ? 13'sd32 : 13'sd0) - 13'sd30;
    assign nsh = 6'(-sh);

    always_comb
    begin
        if (sh > 13'sd33) begin
            res_next = '1;
        end
        else if (sh >= 13'sd0) begin
            res_next = {32'd0, m_reg} << sh[5:0];
        end
        else if (sh <= -13'sd32) begin
            res_next = 64'd0;
        end
        else begin
            res_next = ({32'd0, m_reg} + (64'd1 << (nsh - 6'd1))) >> nsh;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg) begin
                if (cnt_reg[4]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    // Mantissa and result registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start) begin
            m_reg     <= 32'd1 << 30;
            fr_reg    <= expo[15:0];
            ip_reg    <= expo[27:16];
            scale_reg <= ctl.scale32;
        end
        else if (busy_reg) begin
            if (!cnt_reg[4] && fr_bit) begin
                m_reg <= prod_rnd[31:0];
            end
            if (cnt_reg[4]) begin
                res_reg <= res_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/core/fobs_divsqrt.sv]
// Shared shift-and-subtract unit: restoring division or integer square root.
module fobs_divsqrt
    import fobs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ds_ctl_t     ctl,
    input  logic [63:0] src,
    input  logic [31:0] den,
    output logic        done,
    output logic [35:0] quot,
    output logic [33:0] rem
);

    logic        busy_reg;
    logic        sqrt_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] src_reg;
    logic [31:0] den_reg;
    logic [35:0] q_reg;
    logic [33:0] rem_reg;

    logic [33:0] shifted;
    logic [33:0] trial;
    logic [34:0] diff;
    logic        ge;

    // One digit per cycle through a single subtractor.
    assign shifted = sqrt_reg ? {rem_reg[31:0], src_reg[63:62]} : {rem_reg[32:0], src_reg[63]};
    assign trial   = sqrt_reg ? {q_reg[31:0], 2'b01} : {2'b00, den_reg};
    assign diff    = {1'b0, shifted} - {1'b0, trial};
    assign ge      = !diff[34];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.sqrt_mode ? 6'd32 : 6'd36;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand, quotient and remainder registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start) begin
            sqrt_reg <= ctl.sqrt_mode;
            src_reg  <= src;
            den_reg  <= den;
            q_reg    <= 36'd0;
            rem_reg  <= 34'd0;
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[33:0] : shifted;
            q_reg   <= {q_reg[34:0], ge};
            src_reg <= sqrt_reg ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/fractional_octave_band_sum_top.sv]
// Fractional-octave band summer: sequencer, band state and output register.
// For a nonzero line the leading-one search shifts one bit per cycle, followed by a pass
// of the power-of-two unit. A band close adds a division and a square root in the shared
// divide unit, one 2^x pass and, for a nonzero centre, a second division.
// A zero-frequency line without a band to flush goes only through the last-line check.
// Reset clears the band state and loads 3 bands per octave and a window gain of 65535.
module fractional_octave_band_sum_top
    import fobs_pkg::*;
#(
    parameter int COUNT_MAX = 4095
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // line_freq[27:0], level_db[43:28], zero
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // band_index, center_freq, amplitude, velocity,
                                    // line_count, zero (from the lowest bit up)
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [11:0] CNT_SAT = 12'(COUNT_MAX < 4095 ? COUNT_MAX : 4095);

    seq_state_t state_reg, state_next;

    logic [5:0]         bands_reg;
    logic [15:0]        gain_reg;

    logic [27:0]        freq_reg;
    logic [4:0]         p_reg;
    logic signed [15:0] lvl_reg;
    logic               last_reg;
    logic [16:0]        lo_reg;
    logic [16:0]        hi_reg;
    logic [21:0]        log_reg;
    logic signed [10:0] k_reg;
    logic [63:0]        pwr_reg;

    logic signed [10:0] cur_band_reg;
    logic [63:0]        sum_reg;
    logic [11:0]        cnt_reg;
    logic               open_reg;
    logic               fin_reg;

    logic [31:0]        center_reg;
    logic [32:0]        r_reg;
    logic [31:0]        amp_reg;
    logic [61:0]        vnum_reg;
    logic [31:0]        vel_reg;

    logic               m_valid_reg;
    logic [10:0]        o_band_reg;
    logic [31:0]        o_center_reg;
    logic [31:0]        o_amp_reg;
    logic [31:0]        o_vel_reg;
    logic [11:0]        o_cnt_reg;
    logic               o_fin_reg;

    logic               in_take;
    logic               out_free;
    logic [5:0]         eb;

    logic [LOG_TAB_AW-1:0] tab_idx;
    logic [16:0]        tab_q;
    logic [16:0]        diff_lh;
    logic [29:0]        rem_q30;
    logic [46:0]        interp;
    logic [16:0]        frac;

    logic signed [23:0] d_log;
    logic signed [30:0] bd;
    logic signed [30:0] bd_rnd;
    logic signed [14:0] kw;
    logic signed [10:0] k_clamp;

    logic signed [40:0] lvl_prod;
    logic signed [40:0] lvl_rnd;
    logic signed [27:0] e_level;
    logic signed [27:0] e_center;

    logic [10:0]        mag;
    logic [26:0]        q_num;
    logic [64:0]        sum_add;
    logic [63:0]        sum_sat;
    logic [49:0]        amp_prod;
    logic [33:0]        amp_full;
    logic [63:0]        vsum;
    logic [32:0]        r_next;

    exp_ctl_t           exp_ctl;
    logic signed [27:0] exp_e;
    logic               exp_done;
    logic [63:0]        exp_res;

    ds_ctl_t            ds_ctl;
    logic [63:0]        ds_src;
    logic [31:0]        ds_den;
    logic               ds_done;
    logic [35:0]        ds_q;
    logic [33:0]        ds_rem;

    assign in_take   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Effective bands per octave.
    assign eb = (bands_reg == 6'd0) ? 6'd1 : ((bands_reg > BANDS_MAX) ? BANDS_MAX : bands_reg);

    // Log table lookup and linear interpolation.
    assign tab_idx = (state_reg == ST_LOG_HI) ? ({1'b0, freq_reg[26:19]} + 9'd1)
                                              : {1'b0, freq_reg[26:19]};
    assign tab_q   = LOG_TAB[tab_idx];
    assign diff_lh = hi_reg - lo_reg;
    assign rem_q30 = {freq_reg[18:0], 11'd0};
    assign interp  = 47'(diff_lh) * 47'(rem_q30);
    assign frac    = (hi_reg > lo_reg) ? (lo_reg + 17'((interp + 47'(64'd1 << 29)) >> 30))
                                       : lo_reg;

    // Band number from the log frequency.
    assign d_log   = $signed({2'b00, log_reg}) - $signed({4'd0, LOG2_16000_Q16});
    assign bd      = $signed({25'd0, eb}) * 31'(d_log);
    assign bd_rnd  = (bd + 31'sd32768) >>> 16;
    assign kw      = bd_rnd[14:0];
    assign k_clamp = (kw < -15'sd1024) ? -11'sd1024 : ((kw > 15'sd1023) ? 11'sd1023 : kw[10:0]);

    // Line power exponent from the level in dB.
    assign lvl_prod = 41'(lvl_reg) * $signed({17'd0, LOG2_10_DIV10});
    assign lvl_rnd  = (lvl_prod + 41'sd32768) >>> 16;
    assign e_level  = lvl_rnd[27:0];

    // Centre exponent from the band quotient.
    assign mag      = cur_band_reg[10] ? 11'(-cur_band_reg) : cur_band_reg;
    assign q_num    = {mag, 16'd0} + 27'(eb >> 1);
    assign e_center = cur_band_reg[10]
                    ? ($signed({8'd0, LOG2_16000_Q16}) - $signed({1'b0, ds_q[26:0]}))
                    : ($signed({8'd0, LOG2_16000_Q16}) + $signed({1'b0, ds_q[26:0]}));

    // Saturating power accumulation.
    assign sum_add = open_reg ? ({1'b0, sum_reg} + {1'b0, pwr_reg}) : {1'b0, pwr_reg};
    assign sum_sat = sum_add[64] ? '1 : sum_add[63:0];

    // Amplitude, rounding of the root and velocity numerator.
    assign r_next   = {1'b0, ds_q[31:0]} + 33'(ds_rem > {2'b00, ds_q[31:0]});
    assign amp_prod = 50'(r_reg) * 50'(gain_reg) + 50'd32768;
    assign amp_full = amp_prod[49:16];
    assign vsum     = {2'b00, vnum_reg} + {5'd0, center_reg, 27'd0};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take) begin
                    state_next = (s_tdata[27:0] == 28'd0) ? ST_CHECK_LAST : ST_NORM;
                end
            end
            ST_NORM:       state_next = freq_reg[27] ? ST_LOG_LO : ST_NORM;
            ST_LOG_LO:     state_next = ST_LOG_HI;
            ST_LOG_HI:     state_next = ST_LOG_SUM;
            ST_LOG_SUM:    state_next = ST_BAND;
            ST_BAND:       state_next = ST_LEVEL;
            ST_LEVEL:      state_next = ST_PWR_WAIT;
            ST_PWR_WAIT:   state_next = exp_done ? ST_DECIDE : ST_PWR_WAIT;
            ST_DECIDE:
            begin
                state_next = (open_reg && (k_reg > cur_band_reg)) ? ST_Q_START : ST_ACCUM;
            end
            ST_ACCUM:      state_next = ST_CHECK_LAST;
            ST_CHECK_LAST: state_next = (last_reg && open_reg) ? ST_Q_START : ST_IDLE;
            ST_Q_START:    state_next = ST_Q_WAIT;
            ST_Q_WAIT:     state_next = ds_done ? ST_CEN_START : ST_Q_WAIT;
            ST_CEN_START:  state_next = ST_CEN_WAIT;
            ST_CEN_WAIT:   state_next = exp_done ? ST_SQRT_START : ST_CEN_WAIT;
            ST_SQRT_START: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:  state_next = ds_done ? ST_AMP : ST_SQRT_WAIT;
            ST_AMP:        state_next = ST_VMUL;
            ST_VMUL:       state_next = ST_VDIV_START;
            ST_VDIV_START: state_next = (center_reg == 32'd0) ? ST_EMIT : ST_VDIV_WAIT;
            ST_VDIV_WAIT:  state_next = ds_done ? ST_EMIT : ST_VDIV_WAIT;
            ST_EMIT:
            begin
                if (out_free) begin
                    state_next = fin_reg ? ST_IDLE : ST_ACCUM;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and unit requests.
    always_comb
    begin
        s_tready          = 1'b0;
        exp_ctl.start     = 1'b0;
        exp_ctl.scale32   = 1'b0;
        exp_e             = e_center;
        ds_ctl.start      = 1'b0;
        ds_ctl.sqrt_mode  = 1'b0;
        ds_src            = {vsum[63:28], 28'd0};
        ds_den            = center_reg;
        unique case (state_reg)
            ST_IDLE:       s_tready = 1'b1;
            ST_LEVEL:
            begin
                exp_ctl.start   = 1'b1;
                exp_ctl.scale32 = 1'b1;
                exp_e           = e_level;
            end
            ST_CEN_START:  exp_ctl.start = 1'b1;
            ST_Q_START:
            begin
                ds_ctl.start = 1'b1;
                ds_src       = {9'd0, q_num, 28'd0};
                ds_den       = {26'd0, eb};
            end
            ST_SQRT_START:
            begin
                ds_ctl.start     = 1'b1;
                ds_ctl.sqrt_mode = 1'b1;
                ds_src           = sum_reg;
            end
            ST_VDIV_START: ds_ctl.start = (center_reg != 32'd0);
            default:       s_tready = 1'b0;
        endcase
    end

    // State register and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            bands_reg    <= 6'd3;
            gain_reg     <= 16'hFFFF;
            open_reg     <= 1'b0;
            cur_band_reg <= 11'sd0;
            sum_reg      <= 64'd0;
            cnt_reg      <= 12'd0;
            m_valid_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_BANDS: bands_reg <= cfg_data[5:0];
                    REG_GAIN:  gain_reg  <= cfg_data;
                    default:   gain_reg  <= gain_reg;
                endcase
            end
            // The emit state refills the output register itself.
            if (m_valid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ACCUM:
                begin
                    if (!open_reg) begin
                        cur_band_reg <= k_reg;
                        cnt_reg      <= 12'd1;
                    end
                    else if (cnt_reg < CNT_SAT) begin
                        cnt_reg <= cnt_reg + 12'd1;
                    end
                    sum_reg  <= sum_sat;
                    open_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        open_reg    <= 1'b0;
                        if (fin_reg) begin
                            cur_band_reg <= 11'sd0;
                            sum_reg      <= 64'd0;
                            cnt_reg      <= 12'd0;
                        end
                    end
                end
                default:
                begin
                    open_reg <= open_reg;
                end
            endcase
        end
    end

    // Line and band-close working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take) begin
                    freq_reg <= s_tdata[27:0];
                    lvl_reg  <= s_tdata[43:28];
                    last_reg <= s_tlast;
                    p_reg    <= 5'd27;
                end
            end
            ST_NORM:
            begin
                if (!freq_reg[27]) begin
                    freq_reg <= freq_reg << 1;
                    p_reg    <= p_reg - 5'd1;
                end
            end
            ST_LOG_LO:    lo_reg  <= tab_q;
            ST_LOG_HI:    hi_reg  <= tab_q;
            ST_LOG_SUM:   log_reg <= {1'b0, p_reg, 16'd0} + 22'(frac);
            ST_BAND:      k_reg   <= k_clamp;
            ST_PWR_WAIT:  pwr_reg <= exp_res;
            ST_DECIDE:    fin_reg <= 1'b0;
            ST_CHECK_LAST: fin_reg <= 1'b1;
            ST_CEN_WAIT:  center_reg <= (exp_res[63:32] != 32'd0) ? '1 : exp_res[31:0];
            ST_SQRT_WAIT: r_reg   <= r_next;
            ST_AMP:       amp_reg <= (amp_full[33:32] != 2'd0) ? '1 : amp_full[31:0];
            ST_VMUL:      vnum_reg <= 62'(amp_reg) * 62'(INV_TWO_PI_Q32);
            ST_VDIV_START: vel_reg <= 32'd0;
            ST_VDIV_WAIT: vel_reg <= (ds_q[35:32] != 4'd0) ? '1 : ds_q[31:0];
            ST_EMIT:
            begin
                if (out_free) begin
                    o_band_reg   <= cur_band_reg;
                    o_center_reg <= center_reg;
                    o_amp_reg    <= amp_reg;
                    o_vel_reg    <= vel_reg;
                    o_cnt_reg    <= cnt_reg;
                    o_fin_reg    <= fin_reg;
                end
            end
            default:      last_reg <= last_reg;
        endcase
    end

    // Shared power-of-two unit.
    fobs_exp2 u_exp2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (exp_ctl),
        .expo   (exp_e),
        .done   (exp_done),
        .result (exp_res)
    );

    // Shared divide and square-root unit.
    fobs_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ds_ctl),
        .src   (ds_src),
        .den   (ds_den),
        .done  (ds_done),
        .quot  (ds_q),
        .rem   (ds_rem)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_cnt_reg, o_vel_reg, o_amp_reg, o_center_reg, o_band_reg};
    assign m_tlast  = o_fin_reg;

    // An open band always holds at least one line.
    assert property (@(posedge clk) disable iff (!rst_n) open_reg |-> (cnt_reg != 12'd0))
        else $error("open band with zero line count");

    // The power-of-two unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        exp_done |-> (state_reg == ST_PWR_WAIT || state_reg == ST_CEN_WAIT))
        else $error("power-of-two result arrived in an unexpected state");

    // The divide unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> (state_reg == ST_Q_WAIT || state_reg == ST_SQRT_WAIT
                     || state_reg == ST_VDIV_WAIT))
        else $error("divide result arrived in an unexpected state");

    // After taking a request the block is busy in the cycle that follows.
    assert property (@(posedge clk) disable iff (!rst_n) in_take |=> !s_tready)
        else $error("request taken on back-to-back cycles");

endmodule

[tb/fractional_octave_band_sum_top_test.sv]
// Self-checking testbench for the fractional-octave band summer, with its own bit-true band predictor.
module fractional_octave_band_sum_top_test;
    import fobs_pkg::*;

    // One emitted band as the block should present it.
    typedef struct {
        logic [10:0] band_index;
        logic [31:0] center_freq;
        logic [31:0] amplitude;
        logic [31:0] velocity;
        logic [11:0] line_count;
        logic        final_band;
    } band_res_t;

    // One row of the directed stimulus; want_n is the number of bands expected, or -1.
    typedef struct {
        logic [27:0] freq;
        logic [15:0] level;
        bit          last;
        int          want_n;
    } line_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;   // line_freq[27:0], level_db[43:28], zero
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;   // band_index, center_freq, amplitude, velocity, line_count, zero
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [15:0]  cfg_data;

    // Predictor state and tables.
    longint unsigned log2_frac_tab [0:256];
    longint unsigned exp_root_tab [0:15];
    logic [5:0]      bands_reg;
    logic [15:0]     gain_reg;
    longint          open_band;
    longint unsigned band_power;
    int unsigned     band_lines;
    bit              band_is_open;
    band_res_t       band_expect_q [$];
    int              bands_from_line;
    int              errors;
    bit              calm;
    bit              hold_req;
    int              lines_sent;

    fractional_octave_band_sum_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of two units.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Log and root tables, built the same way as the hardware's constants.
    task automatic build_tables();
        longint unsigned x;
        longint unsigned acc;
        for (int j = 0; j <= 256; j++)
        begin
            x   = (64'd1 << 30) + ((longint'(j) << 30) / 256);
            acc = 0;
            for (int i = 0; i < 20; i++)
            begin
                x   = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd1 << 31))
                begin
                    x   = x >> 1;
                    acc = acc | 1;
                end
            end
            log2_frac_tab[j] = (acc + 8) >> 4;
        end
        exp_root_tab[0] = int_sqrt(64'd1 << 61);
        for (int i = 1; i < 16; i++)
            exp_root_tab[i] = int_sqrt(exp_root_tab[i - 1] << 30);
    endtask

    // Effective bands per octave after clamping.
    function automatic longint bands_eff();
        if (bands_reg < 1)
            return 1;
        if (bands_reg > 48)
            return 48;
        return bands_reg;
    endfunction

    // log2 of a nonzero frequency in Q16, table with linear interpolation.
    function automatic longint freq_log2(input logic [27:0] f);
        int              p;
        longint unsigned u;
        longint unsigned pos;
        longint unsigned rem;
        longint unsigned j;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned frac;
        p = 27;
        while (p > 0 && f[p] == 1'b0)
            p--;
        u   = (longint'(f) << (30 - p)) - (64'd1 << 30);
        pos = u * 256;
        j   = pos >> 30;
        if (j >= 256)
            j = 255;
        rem  = pos - (j << 30);
        lo   = log2_frac_tab[j];
        hi   = log2_frac_tab[j + 1];
        frac = lo;
        if (hi > lo)
            frac = lo + (((hi - lo) * rem + (64'd1 << 29)) >> 30);
        return longint'(p) * 65536 + longint'(frac);
    endfunction

    // round(2^(e/65536) * 2^s), saturating at 64 bits.
    function automatic longint unsigned pow2_fix(input longint e, input longint s);
        longint          ip;
        longint          fr;
        longint          sh;
        longint unsigned m;
        ip = e >>> 16;
        fr = e - ip * 65536;
        m  = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
            if (fr[15 - i])
                m = (m * exp_root_tab[i] + (64'd1 << 29)) >> 30;
        sh = ip + s - 30;
        if (sh > 33)
            return '1;
        if (sh >= 0)
            return m << sh;
        if (sh <= -32)
            return 0;
        return (m + (64'd1 << (-sh - 1))) >> (-sh);
    endfunction

    // Result of closing the open band.
    function automatic band_res_t close_band(input bit fin);
        band_res_t       res;
        longint          b;
        longint          mag;
        longint          q;
        longint unsigned center;
        longint unsigned r;
        longint unsigned amp;
        longint unsigned vel;
        b      = bands_eff();
        mag    = (open_band < 0) ? -open_band : open_band;
        q      = (mag * 65536 + b / 2) / b;
        center = pow2_fix(longint'(LOG2_16000_Q16) + ((open_band < 0) ? -q : q), 0);
        r      = int_sqrt(band_power);
        if (band_power - r * r > r)
            r++;
        if (center > 64'hFFFF_FFFF)
            center = 64'hFFFF_FFFF;
        amp = (r * gain_reg + 32768) >> 16;
        if (amp > 64'hFFFF_FFFF)
            amp = 64'hFFFF_FFFF;
        vel = 0;
        if (center != 0)
        begin
            vel = (amp * longint'(INV_TWO_PI_Q32) + (center << 27)) / (center << 28);
            if (vel > 64'hFFFF_FFFF)
                vel = 64'hFFFF_FFFF;
        end
        res.band_index  = open_band[10:0];
        res.center_freq = center[31:0];
        res.amplitude   = amp[31:0];
        res.velocity    = vel[31:0];
        res.line_count  = band_lines[11:0];
        res.final_band  = fin;
        return res;
    endfunction

    // Accumulate one accepted line and queue the bands it closes.
    task automatic predict_line(input logic [27:0] f, input logic signed [15:0] lvl,
                                input bit lst);
        longint          k;
        longint unsigned p;
        bands_from_line = 0;
        if (f != 0)
        begin
            k = (bands_eff() * (freq_log2(f) - longint'(LOG2_16000_Q16)) + 32768) >>> 16;
            p = pow2_fix((longint'(lvl) * longint'(LOG2_10_DIV10) + 32768) >>> 16, 32);
            if (k < -1024)
                k = -1024;
            if (k > 1023)
                k = 1023;
            if (band_is_open && k > open_band)
            begin
                band_expect_q.push_back(close_band(1'b0));
                bands_from_line++;
                band_is_open = 1'b0;
            end
            if (!band_is_open)
            begin
                open_band    = k;
                band_power   = 0;
                band_lines   = 0;
                band_is_open = 1'b1;
            end
            band_power = (band_power > ~64'd0 - p) ? ~64'd0 : band_power + p;
            if (band_lines < 4095)
                band_lines++;
        end
        if (lst && band_is_open)
        begin
            band_expect_q.push_back(close_band(1'b1));
            bands_from_line++;
            band_is_open = 1'b0;
            open_band    = 0;
            band_power   = 0;
            band_lines   = 0;
        end
    endtask

    // Compare one output request with the oldest expected band.
    task automatic check_band(input logic [119:0] d, input logic fin);
        band_res_t w;
        if (band_expect_q.size() == 0)
        begin
            $error("unexpected band output, index %0d", $signed(d[10:0]));
            errors++;
            return;
        end
        w = band_expect_q.pop_front();
        if (d[10:0] !== w.band_index)
        begin
            $error("band_index expected %0d got %0d", $signed(w.band_index), $signed(d[10:0]));
            errors++;
        end
        if (d[42:11] !== w.center_freq)
        begin
            $error("center_freq expected %0d got %0d", w.center_freq, d[42:11]);
            errors++;
        end
        if (d[74:43] !== w.amplitude)
        begin
            $error("amplitude expected %0d got %0d", w.amplitude, d[74:43]);
            errors++;
        end
        if (d[106:75] !== w.velocity)
        begin
            $error("velocity expected %0d got %0d", w.velocity, d[106:75]);
            errors++;
        end
        if (d[118:107] !== w.line_count)
        begin
            $error("line_count expected %0d got %0d", w.line_count, d[118:107]);
            errors++;
        end
        if (fin !== w.final_band)
        begin
            $error("final_band expected %0d got %0d", w.final_band, fin);
            errors++;
        end
    endtask

    // Observe accepted requests on every channel at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_band(m_tdata, m_tlast);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BANDS)
                    bands_reg = cfg_data[5:0];
                else
                    gain_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_line(s_tdata[27:0], s_tdata[43:28], s_tlast);
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (2000) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one line, with an optional gap before it, and wait for its acceptance.
    task automatic push_line(input logic [27:0] f, input logic [15:0] lvl, input bit lst);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tdata  <= {4'b0, lvl, f};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lines_sent++;
        @(negedge clk);
    endtask

    // Wait until every expected band has arrived and the block has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (band_expect_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one configuration register.
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One spectrum: mostly rising frequencies, with some zero, stray and descending lines.
    task automatic send_spectrum();
        int          n;
        int          kind;
        logic [31:0] f;
        logic [27:0] fl;
        logic [15:0] lvl;
        bit          lst;
        n = $urandom_range(1, 30);
        f = $urandom >> $urandom_range(4, 31);
        if (f == 0)
            f = 1;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 99);
            f    = f + (f >> $urandom_range(1, 8)) + $urandom_range(0, 3);
            if (f > 32'h0FFF_FFFF)
                f = 32'h0FFF_FFFF;
            if (kind < 5)
                fl = 28'd0;
            else if (kind < 10)
                fl = 28'($urandom);
            else if (kind < 14)
                fl = f[27:0] >> $urandom_range(1, 6);
            else
                fl = f[27:0];
            if ($urandom_range(0, 9) == 0)
                lvl = 16'($urandom);
            else
                lvl = 16'($urandom_range(0, 49152) - 24576);
            lst = ((i == n - 1) && $urandom_range(0, 9) != 0) || $urandom_range(0, 49) == 0;
            push_line(fl, lvl, lst);
        end
    endtask

    // Time limit for the whole run.
    initial
    begin
        #12000000;
        $display("[fractional_octave_band_sum_top] ERROR");
        $finish;
    end

    // Main sequence: reset, directed lines, then random spectra over several settings.
    initial
    begin
        line_row_t   rows [$];
        logic [15:0] phase_bands [6];
        logic [15:0] phase_gain [6];
        int          target;

        rows = '{
            '{28'd0,         16'sd0,      1'b1, 0},
            '{28'd16000,     16'sd0,      1'b0, 0},
            '{28'd16000,     16'sd0,      1'b1, 1},
            '{28'd1,         16'h8000,    1'b0, 0},
            '{28'hFFF_FFFF,  16'h7FFF,    1'b0, 1},
            '{28'hFFF_FFFF,  16'h7FFF,    1'b0, 0},
            '{28'd100,       16'sd24576,  1'b0, 0},
            '{28'd0,         16'sd0,      1'b1, 1},
            '{28'd16000,     -16'sd24576, 1'b0, 0},
            '{28'd16000,     16'sd24576,  1'b0, 0},
            '{28'd32000,     16'sd0,      1'b0, 1},
            '{28'd8000,      16'sd256,    1'b0, 0},
            '{28'd0,         16'sd0,      1'b0, 0},
            '{28'd20159,     16'sd1000,   1'b1, -1},
            '{28'h800_0000,  16'h0001,    1'b0, 0},
            '{28'h555_5555,  16'hAAAA,    1'b0, -1},
            '{28'hAAA_AAAA,  16'h5555,    1'b1, -1}
        };
        phase_bands = '{16'd1, 16'd48, 16'h0040, 16'hFFFF, 16'd24, 16'd3};
        phase_gain  = '{16'd0, 16'hFFFF, 16'd1, 16'd40000, 16'h0000, 16'hFFFF};
        phase_gain[4] = 16'($urandom);

        build_tables();
        bands_reg    = 6'd3;
        gain_reg     = 16'hFFFF;
        open_band    = 0;
        band_power   = 0;
        band_lines   = 0;
        band_is_open = 1'b0;
        errors       = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        lines_sent   = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BANDS;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows under the reset settings.
        foreach (rows[i])
        begin
            push_line(rows[i].freq, rows[i].level, rows[i].last);
            if (rows[i].want_n >= 0 && bands_from_line != rows[i].want_n)
            begin
                $error("row %0d: bands closed expected %0d got %0d",
                       i, rows[i].want_n, bands_from_line);
                errors++;
            end
        end

        // Random spectra, one block of them per register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_reg(REG_BANDS, phase_bands[ph]);
            write_reg(REG_GAIN, phase_gain[ph]);
            calm = (ph == 5);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 4)
            begin
                // One long band whose power sum saturates.
                for (int i = 0; i < 40; i++)
                    push_line(28'd16000, (i % 2) ? 16'h7FFF : 16'h0000, 1'b0);
                push_line(28'd16000, 16'h0000, 1'b1);
            end
            target = lines_sent + 315;
            while (lines_sent < target)
                send_spectrum();
        end

        wait_drained();
        if (errors == 0)
            $display("[fractional_octave_band_sum_top] OK");
        else
            $display("[fractional_octave_band_sum_top] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/fobs_pkg.sv
rtl/core/fobs_exp2.sv
rtl/core/fobs_divsqrt.sv
rtl/core/fractional_octave_band_sum_top.sv
tb/fractional_octave_band_sum_top_test.sv
